// ===== hdl/tod_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the slot table entry type of the displacement filter.
package tod_pkg;

  localparam int ANT_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(ANT_SLOTS);

  localparam int ID_W    = 10;
  localparam int SPACE_W = 8;
  localparam int TIME_W  = 48;
  localparam int POS_W   = 20;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DISP_W  = 43;
  localparam int GAP_W   = 32;
  localparam int CFG_W   = DISP_W;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [0:0] CFG_MAX_DISP_SQ = 1'b0;
  localparam logic [0:0] CFG_MIN_GAP     = 1'b1;

  typedef struct packed {
    logic                      valid;
    logic [SPACE_W-1:0]        space;
    logic [TIME_W-1:0]         frame_time;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [DISP_W-1:0]         disp;
  } entry_t;

endpackage

// ===== hdl/tracked_object_displacement_filter.sv =====
`timescale 1ns / 1ps
// Top level of the tracked object displacement filter with its slot table memory.
//
// Items arrive on the input channel (in_valid, in_stall) and carry either an
// update of one object or a query of a pair of objects. Updates give no
// result; each query gives one item on the output channel (out_valid,
// out_stall) with the matched flag.
// The slot table is one memory of ANT_SLOTS entries with one write port and
// two read ports, and its read data is registered. One item is worked on at
// a time. A query's result is worked out in the execute step and loaded into
// the output register once that register is free.
// An update goes through the table read, the difference and time gap check,
// the two squares, and the write back of the slot.
// The configuration port writes a register at any edge with cfg_write high and rst low.
// After reset the block clears the valid bit of every slot, one slot a cycle,
// and holds in_stall high meanwhile.
// When the receiver stalls, the result item is held in the output register;
// the next item is still accepted and waits only when its own result is due.
module tracked_object_displacement_filter
  import tod_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     command,
  input  logic [ID_W-1:0]          ant_id,
  input  logic [ID_W-1:0]          second_ant_id,
  input  logic [SPACE_W-1:0]       space_id,
  input  logic [TIME_W-1:0]        frame_time,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     matched
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_WB
  } state_t;

  state_t state;

  logic [DISP_W-1:0] max_disp_sq;
  logic [GAP_W-1:0]  min_gap;

  logic              clr_active;
  logic [SLOT_W-1:0] clr_addr;

  entry_t mem [ANT_SLOTS];
  entry_t rd_a;
  entry_t rd_b;

  logic                     cmd_q;
  logic                     id_ok_q;
  logic                     id2_ok_q;
  logic [SLOT_W-1:0]        addr_q;
  logic [SPACE_W-1:0]       space_q;
  logic [TIME_W-1:0]        time_q;
  logic signed [POS_W-1:0]  x_q;
  logic signed [POS_W-1:0]  y_q;
  logic signed [DIFF_W-1:0] dx_q;
  logic signed [DIFF_W-1:0] dy_q;
  logic signed [SQ_W-1:0]   sq_x_q;
  logic signed [SQ_W-1:0]   sq_y_q;
  logic                     move_q;

  logic              in_accept;
  logic [SLOT_W-1:0] addr_a;
  logic [SLOT_W-1:0] addr_b;
  logic              id_ok;
  logic              id2_ok;
  logic [TIME_W:0]   gap;
  logic              gap_over;
  logic              same_space;
  logic              fail_a;
  logic              fail_b;
  logic              out_free;
  logic              out_load;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  assign in_stall  = clr_active || (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign addr_a    = SLOT_W'(ant_id);
  assign addr_b    = SLOT_W'(second_ant_id);
  assign id_ok     = 32'(ant_id) < ANT_SLOTS;
  assign id2_ok    = 32'(second_ant_id) < ANT_SLOTS;

  assign gap        = {1'b0, time_q} - {1'b0, rd_a.frame_time};
  assign gap_over   = !gap[TIME_W] && (gap[TIME_W-1:0] > TIME_W'(min_gap));
  assign same_space = rd_a.valid && (rd_a.space == space_q);
  assign fail_a     = id_ok_q && rd_a.valid && (rd_a.disp > max_disp_sq);
  assign fail_b     = id2_ok_q && rd_b.valid && (rd_b.disp > max_disp_sq);
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = (state == S_EXEC) && (cmd_q == CMD_QUERY) && out_free;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_WB) begin
      mem_we               = 1'b1;
      mem_wdata.valid      = 1'b1;
      mem_wdata.space      = space_q;
      mem_wdata.frame_time = time_q;
      mem_wdata.pos_x      = x_q;
      mem_wdata.pos_y      = y_q;
      mem_wdata.disp       = move_q ?
          DISP_W'($unsigned(sq_x_q)) + DISP_W'($unsigned(sq_y_q)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_disp_sq <= '0;
      min_gap     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_DISP_SQ: max_disp_sq <= cfg_data;
        CFG_MIN_GAP:     min_gap     <= GAP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == SLOT_W'(ANT_SLOTS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        matched   <= !(fail_a || fail_b);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_q == CMD_QUERY) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else if (!id_ok_q) begin
            state <= S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_WB;
        end
        S_WB: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q    <= command;
      id_ok_q  <= id_ok;
      id2_ok_q <= id2_ok;
      addr_q   <= addr_a;
      space_q  <= space_id;
      time_q   <= frame_time;
      x_q      <= pos_x;
      y_q      <= pos_y;
    end
    if (state == S_EXEC) begin
      move_q <= same_space && gap_over;
      dx_q   <= {x_q[POS_W-1], x_q} - {rd_a.pos_x[POS_W-1], rd_a.pos_x};
      dy_q   <= {y_q[POS_W-1], y_q} - {rd_a.pos_y[POS_W-1], rd_a.pos_y};
    end
    if (state == S_MUL) begin
      sq_x_q <= dx_q * dx_q;
      sq_y_q <= dy_q * dy_q;
    end
  end

`ifndef SYNTHESIS
  a_stall_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> in_stall)
    else $error("Input accepted during the table clearing pass.");

  a_wb_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> ($past(state) == S_MUL))
    else $error("Slot write back without a preceding multiply step.");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EXEC && $past(cmd_q) == CMD_QUERY))
    else $error("Result item raised without a query in progress.");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_EXEC))
    else $error("Accepted item did not enter the execute step.");
`endif

endmodule
